// ----- hw/rtl/kltok_pkg.sv -----
// Shared types and constants for the keyword lexer tokenizer.
// Used by every module of the block; it depends on nothing else.
`default_nettype none

package kltok_pkg;

    localparam int BYTE_W         = 8;
    localparam int KIND_W         = 5;
    localparam int TOKEN_START_W  = 32;
    localparam int TOKEN_LENGTH_W = 16;
    localparam int KW_BYTES       = 6;
    localparam int KW_IDX_W       = 3;
    localparam int KW_COUNT       = 12;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_IDENT      = 3'd1,
        MODE_NUMBER     = 3'd2,
        MODE_MINUS      = 3'd3,
        MODE_SLASH      = 3'd4,
        MODE_LINE       = 3'd5,
        MODE_BLOCK      = 3'd6,
        MODE_BLOCK_STAR = 3'd7
    } mode_t;

    localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd0;
    localparam logic [KIND_W-1:0] KIND_PUB     = 5'd1;
    localparam logic [KIND_W-1:0] KIND_FN      = 5'd2;
    localparam logic [KIND_W-1:0] KIND_STRUCT  = 5'd3;
    localparam logic [KIND_W-1:0] KIND_ENUM    = 5'd4;
    localparam logic [KIND_W-1:0] KIND_IMPL    = 5'd5;
    localparam logic [KIND_W-1:0] KIND_IF      = 5'd6;
    localparam logic [KIND_W-1:0] KIND_ELSE    = 5'd7;
    localparam logic [KIND_W-1:0] KIND_FOR     = 5'd8;
    localparam logic [KIND_W-1:0] KIND_INT     = 5'd9;
    localparam logic [KIND_W-1:0] KIND_PLUS    = 5'd10;
    localparam logic [KIND_W-1:0] KIND_MINUS   = 5'd11;
    localparam logic [KIND_W-1:0] KIND_STAR    = 5'd12;
    localparam logic [KIND_W-1:0] KIND_SLASH   = 5'd13;
    localparam logic [KIND_W-1:0] KIND_SEMI    = 5'd14;
    localparam logic [KIND_W-1:0] KIND_COLON   = 5'd15;
    localparam logic [KIND_W-1:0] KIND_LPAR    = 5'd16;
    localparam logic [KIND_W-1:0] KIND_RPAR    = 5'd17;
    localparam logic [KIND_W-1:0] KIND_LCURL   = 5'd18;
    localparam logic [KIND_W-1:0] KIND_RCURL   = 5'd19;
    localparam logic [KIND_W-1:0] KIND_ARROW   = 5'd20;
    localparam logic [KIND_W-1:0] KIND_CHAR    = 5'd21;
    localparam logic [KIND_W-1:0] KIND_I32     = 5'd22;
    localparam logic [KIND_W-1:0] KIND_RET     = 5'd23;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 5'd24;

    localparam logic [BYTE_W-1:0] CH_TAB        = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF         = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR         = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [BYTE_W-1:0] CH_LPAR       = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAR       = 8'h29;
    localparam logic [BYTE_W-1:0] CH_STAR       = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_PLUS       = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_SLASH      = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_DIGIT_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_DIGIT_9    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_COLON      = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_SEMI       = 8'h3B;
    localparam logic [BYTE_W-1:0] CH_GT         = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_LCURL      = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RCURL      = 8'h7D;

    // Keyword text, first character in the lowest byte, unused bytes zero.
    localparam logic [KW_BYTES*BYTE_W-1:0] KW_TEXT [KW_COUNT] = '{
        {8'h00, 8'h00, 8'h00, 8'h00, "n", "f"},
        {8'h00, 8'h00, 8'h00, "b", "u", "p"},
        {"t", "c", "u", "r", "t", "s"},
        {8'h00, 8'h00, "m", "u", "n", "e"},
        {8'h00, 8'h00, "l", "p", "m", "i"},
        {8'h00, 8'h00, 8'h00, 8'h00, "f", "i"},
        {8'h00, 8'h00, "e", "s", "l", "e"},
        {8'h00, 8'h00, 8'h00, "r", "o", "f"},
        {8'h00, 8'h00, "r", "a", "h", "c"},
        {8'h00, 8'h00, 8'h00, "2", "3", "i"},
        {8'h00, 8'h00, 8'h00, "t", "e", "r"},
        {"n", "r", "u", "t", "e", "r"}
    };

    localparam logic [KW_IDX_W-1:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd3, 3'd6, 3'd4, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd3, 3'd3, 3'd6
    };

    localparam logic [KIND_W-1:0] KW_KIND [KW_COUNT] = '{
        KIND_FN, KIND_PUB, KIND_STRUCT, KIND_ENUM, KIND_IMPL, KIND_IF,
        KIND_ELSE, KIND_FOR, KIND_CHAR, KIND_I32, KIND_RET, KIND_RET
    };

    typedef struct packed {
        logic                             short_len;
        logic [KW_IDX_W-1:0]              len;
        logic [KW_BYTES-1:0][BYTE_W-1:0]  text;
    } kw_query_t;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [TOKEN_START_W-1:0]  start;
        logic [TOKEN_LENGTH_W-1:0] length;
        logic                      last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } res_load_t;

endpackage

`default_nettype wire

// ----- hw/rtl/kltok_kw_match.sv -----
// Parallel keyword compare over the six-byte identifier buffer.
// Depends on kltok_pkg for the keyword table and the query type.
`default_nettype none

module kltok_kw_match (
    input  kltok_pkg::kw_query_t                  query,
    output logic [kltok_pkg::KIND_W-1:0]          kind
);

    always_comb begin
        logic hit;
        kind = kltok_pkg::KIND_IDENT;
        // Walk backward so that the first table entry that matches wins.
        for (int k = kltok_pkg::KW_COUNT - 1; k >= 0; k--) begin
            hit = query.short_len && (query.len == kltok_pkg::KW_LEN[k]);
            for (int i = 0; i < kltok_pkg::KW_BYTES; i++) begin
                if ((kltok_pkg::KW_IDX_W'(i) < kltok_pkg::KW_LEN[k]) &&
                    (query.text[i] != kltok_pkg::KW_TEXT[k][i*kltok_pkg::BYTE_W +:
                                                             kltok_pkg::BYTE_W])) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                kind = kltok_pkg::KW_KIND[k];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/kltok_scanner.sv -----
// Lexer state registers and the per-byte scan logic that forms up to two tokens.
// Depends on kltok_pkg and instantiates kltok_kw_match twice.
`default_nettype none

module kltok_scanner #(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic [kltok_pkg::BYTE_W-1:0]     text_byte,
    input  logic                             end_of_text,
    output kltok_pkg::res_load_t             load
);

    localparam int StartW = kltok_pkg::TOKEN_START_W;
    localparam int LenW   = kltok_pkg::TOKEN_LENGTH_W;
    localparam int KwB    = kltok_pkg::KW_BYTES;
    localparam int ByteW  = kltok_pkg::BYTE_W;

    kltok_pkg::mode_t                   mode_reg, mode_next, mode_mid;
    logic [KwB-1:0][ByteW-1:0]          kwbuf_reg, kwbuf_next;
    logic [POSITION_BITS-1:0]           start_reg, start_next;
    logic [POSITION_BITS-1:0]           pos_reg, pos_next;
    logic [LENGTH_BITS-1:0]             len_reg, len_next, len_grown;

    kltok_pkg::kw_query_t               q_cur, q_new;
    logic [kltok_pkg::KIND_W-1:0]       kind_cur, kind_new;

    logic                               is_alpha, is_digit, is_space, is_word;
    kltok_pkg::mode_t                   beg_mode;
    logic                               beg_emit;
    logic [kltok_pkg::KIND_W-1:0]       beg_kind;

    logic                               pend_v, begin_v, flush_v, do_begin;
    kltok_pkg::token_t                  pend_tok, begin_tok, flush_tok;

    assign is_alpha = (text_byte inside {[kltok_pkg::CH_LOWER_A:kltok_pkg::CH_LOWER_Z],
                                         [kltok_pkg::CH_UPPER_A:kltok_pkg::CH_UPPER_Z]});
    assign is_digit = (text_byte inside {[kltok_pkg::CH_DIGIT_0:kltok_pkg::CH_DIGIT_9]});
    assign is_space = (text_byte inside {kltok_pkg::CH_SPACE,
                                         [kltok_pkg::CH_TAB:kltok_pkg::CH_CR]});
    assign is_word  = is_alpha || is_digit || (text_byte == kltok_pkg::CH_UNDERSCORE);

    assign len_grown = (&len_reg) ? len_reg : len_reg + LENGTH_BITS'(1);

    assign q_cur.short_len = (len_reg <= LENGTH_BITS'(KwB));
    assign q_cur.len       = len_reg[kltok_pkg::KW_IDX_W-1:0];
    assign q_cur.text      = kwbuf_reg;
    assign q_new.short_len = (len_next <= LENGTH_BITS'(KwB));
    assign q_new.len       = len_next[kltok_pkg::KW_IDX_W-1:0];
    assign q_new.text      = kwbuf_next;

    kltok_kw_match u_kw_cur (
        .query (q_cur),
        .kind  (kind_cur)
    );

    kltok_kw_match u_kw_new (
        .query (q_new),
        .kind  (kind_new)
    );

    // Effect of a byte that opens a new token.
    always_comb begin
        beg_mode = kltok_pkg::MODE_IDLE;
        beg_emit = 1'b0;
        beg_kind = kltok_pkg::KIND_UNKNOWN;
        if (is_space) begin
            beg_mode = kltok_pkg::MODE_IDLE;
        end else if (is_alpha || text_byte == kltok_pkg::CH_UNDERSCORE) begin
            beg_mode = kltok_pkg::MODE_IDENT;
        end else if (is_digit) begin
            beg_mode = kltok_pkg::MODE_NUMBER;
        end else if (text_byte == kltok_pkg::CH_MINUS) begin
            beg_mode = kltok_pkg::MODE_MINUS;
        end else if (text_byte == kltok_pkg::CH_SLASH) begin
            beg_mode = kltok_pkg::MODE_SLASH;
        end else begin
            beg_emit = 1'b1;
            case (text_byte)
                kltok_pkg::CH_PLUS:  beg_kind = kltok_pkg::KIND_PLUS;
                kltok_pkg::CH_STAR:  beg_kind = kltok_pkg::KIND_STAR;
                kltok_pkg::CH_SEMI:  beg_kind = kltok_pkg::KIND_SEMI;
                kltok_pkg::CH_COLON: beg_kind = kltok_pkg::KIND_COLON;
                kltok_pkg::CH_LPAR:  beg_kind = kltok_pkg::KIND_LPAR;
                kltok_pkg::CH_RPAR:  beg_kind = kltok_pkg::KIND_RPAR;
                kltok_pkg::CH_LCURL: beg_kind = kltok_pkg::KIND_LCURL;
                kltok_pkg::CH_RCURL: beg_kind = kltok_pkg::KIND_RCURL;
                default:             beg_kind = kltok_pkg::KIND_UNKNOWN;
            endcase
        end
    end

    // Byte handling in the current mode.
    always_comb begin
        mode_mid   = mode_reg;
        kwbuf_next = kwbuf_reg;
        start_next = start_reg;
        len_next   = len_reg;
        pos_next   = en ? pos_reg + POSITION_BITS'(1) : pos_reg;
        pend_v     = 1'b0;
        pend_tok   = '0;
        do_begin   = 1'b0;
        begin_v    = 1'b0;
        begin_tok  = '0;
        if (en) begin
            case (mode_reg)
                kltok_pkg::MODE_IDENT: begin
                    if (is_word) begin
                        if (len_reg < LENGTH_BITS'(KwB)) begin
                            kwbuf_next[len_reg[kltok_pkg::KW_IDX_W-1:0]] = text_byte;
                        end
                        len_next = len_grown;
                    end else begin
                        pend_v   = 1'b1;
                        pend_tok = '{kind_cur, StartW'(start_reg), LenW'(len_reg), 1'b0};
                        do_begin = 1'b1;
                    end
                end
                kltok_pkg::MODE_NUMBER: begin
                    if (is_digit) begin
                        len_next = len_grown;
                    end else begin
                        pend_v   = 1'b1;
                        pend_tok = '{kltok_pkg::KIND_INT, StartW'(start_reg),
                                     LenW'(len_reg), 1'b0};
                        do_begin = 1'b1;
                    end
                end
                kltok_pkg::MODE_MINUS: begin
                    mode_mid = kltok_pkg::MODE_IDLE;
                    pend_v   = 1'b1;
                    if (text_byte == kltok_pkg::CH_GT) begin
                        pend_tok = '{kltok_pkg::KIND_ARROW, StartW'(start_reg),
                                     LenW'(2), 1'b0};
                    end else begin
                        pend_tok = '{kltok_pkg::KIND_MINUS, StartW'(start_reg),
                                     LenW'(1), 1'b0};
                        do_begin = 1'b1;
                    end
                end
                kltok_pkg::MODE_SLASH: begin
                    if (text_byte == kltok_pkg::CH_STAR) begin
                        mode_mid = kltok_pkg::MODE_BLOCK;
                    end else if (text_byte == kltok_pkg::CH_SLASH) begin
                        mode_mid = kltok_pkg::MODE_LINE;
                    end else begin
                        pend_v   = 1'b1;
                        pend_tok = '{kltok_pkg::KIND_SLASH, StartW'(start_reg),
                                     LenW'(1), 1'b0};
                        do_begin = 1'b1;
                    end
                end
                kltok_pkg::MODE_LINE: begin
                    if (text_byte == kltok_pkg::CH_LF || text_byte == kltok_pkg::CH_CR) begin
                        mode_mid = kltok_pkg::MODE_IDLE;
                    end
                end
                kltok_pkg::MODE_BLOCK: begin
                    if (text_byte == kltok_pkg::CH_STAR) begin
                        mode_mid = kltok_pkg::MODE_BLOCK_STAR;
                    end
                end
                kltok_pkg::MODE_BLOCK_STAR: begin
                    if (text_byte == kltok_pkg::CH_SLASH) begin
                        mode_mid = kltok_pkg::MODE_IDLE;
                    end else if (text_byte != kltok_pkg::CH_STAR) begin
                        mode_mid = kltok_pkg::MODE_BLOCK;
                    end
                end
                default: begin
                    do_begin = 1'b1;
                end
            endcase
            if (do_begin) begin
                mode_mid   = beg_mode;
                start_next = pos_reg;
                len_next   = LENGTH_BITS'(1);
                if (beg_mode == kltok_pkg::MODE_IDENT) begin
                    kwbuf_next[0] = text_byte;
                end
                begin_v   = beg_emit;
                begin_tok = '{beg_kind, StartW'(pos_reg), LenW'(1), 1'b0};
            end
        end
    end

    // End of text flushes whatever token is still open.
    always_comb begin
        flush_v   = 1'b0;
        flush_tok = '0;
        mode_next = mode_mid;
        if (en && end_of_text) begin
            mode_next = kltok_pkg::MODE_IDLE;
            case (mode_mid)
                kltok_pkg::MODE_IDENT: begin
                    flush_v   = 1'b1;
                    flush_tok = '{kind_new, StartW'(start_next), LenW'(len_next), 1'b0};
                end
                kltok_pkg::MODE_NUMBER: begin
                    flush_v   = 1'b1;
                    flush_tok = '{kltok_pkg::KIND_INT, StartW'(start_next),
                                  LenW'(len_next), 1'b0};
                end
                kltok_pkg::MODE_MINUS: begin
                    flush_v   = 1'b1;
                    flush_tok = '{kltok_pkg::KIND_MINUS, StartW'(start_next),
                                  LenW'(1), 1'b0};
                end
                kltok_pkg::MODE_SLASH: begin
                    flush_v   = 1'b1;
                    flush_tok = '{kltok_pkg::KIND_SLASH, StartW'(start_next),
                                  LenW'(1), 1'b0};
                end
                default: begin
                    flush_v = 1'b0;
                end
            endcase
        end
    end

    // Order is pending token, then the token the byte opens, then the flush.
    always_comb begin
        load.count = {1'b0, pend_v} + {1'b0, begin_v} + {1'b0, flush_v};
        load.tok0  = flush_tok;
        load.tok1  = flush_tok;
        if (pend_v) begin
            load.tok0 = pend_tok;
            load.tok1 = begin_v ? begin_tok : flush_tok;
        end else if (begin_v) begin
            load.tok0 = begin_tok;
        end
        load.tok0.last = (load.count == 2'd1);
        load.tok1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= kltok_pkg::MODE_IDLE;
            start_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
        end else begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        kwbuf_reg <= kwbuf_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/kltok_result_buf.sv -----
// Two-entry result register that holds the tokens of one byte and hands them out in order.
// Depends on kltok_pkg for the token and load types.
`default_nettype none

module kltok_result_buf (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   load_en,
    input  kltok_pkg::res_load_t                   load,
    output logic                                   can_load,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [kltok_pkg::KIND_W-1:0]           m_token_kind,
    output logic [kltok_pkg::TOKEN_START_W-1:0]    m_token_start,
    output logic [kltok_pkg::TOKEN_LENGTH_W-1:0]   m_token_length,
    output logic                                   m_last_of_run
);

    logic [1:0]          count_reg, count_next;
    kltok_pkg::token_t   slot0_reg, slot0_next;
    kltok_pkg::token_t   slot1_reg, slot1_next;

    assign can_load = (count_reg == 2'd0) || (count_reg == 2'd1 && m_ready);

    assign m_valid        = (count_reg != 2'd0);
    assign m_token_kind   = slot0_reg.kind;
    assign m_token_start  = slot0_reg.start;
    assign m_token_length = slot0_reg.length;
    assign m_last_of_run  = slot0_reg.last;

    always_comb begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load_en) begin
            count_next = load.count;
            slot0_next = load.tok0;
            slot1_next = load.tok1;
        end else if (m_valid && m_ready) begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/keyword_lexer_tokenizer_core.sv -----
// Top level of the keyword lexer tokenizer: input register, scanner and result register.
// Depends on kltok_pkg, kltok_scanner and kltok_result_buf.
//
//   Channel  Direction  Handshake           Carries
//   s_       in         s_valid / s_ready   one source byte and its end-of-text flag
//   m_       out        m_valid / m_ready   one token: kind, start, length, last_of_run
//
// A byte is held in the input register and scanned once the result register can take its
// tokens; its first token is then presented from the result register.
// One byte per cycle is sustained while each byte yields at most one token and m_ready stays
// high; a byte that yields two tokens stalls the scan while both wait to be taken.
// The scan advances when the two-entry result register is empty or its one token is taken.
// Reset is synchronous and active low; the identifier buffer is not reset.
`default_nettype none

module keyword_lexer_tokenizer_core #(
    parameter int POSITION_BITS = 32,
    parameter int LENGTH_BITS   = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [kltok_pkg::BYTE_W-1:0]           s_text_byte,
    input  logic                                   s_end_of_text,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [kltok_pkg::KIND_W-1:0]           m_token_kind,
    output logic [kltok_pkg::TOKEN_START_W-1:0]    m_token_start,
    output logic [kltok_pkg::TOKEN_LENGTH_W-1:0]   m_token_length,
    output logic                                   m_last_of_run
);

    logic                              in_valid_reg, in_valid_next;
    logic [kltok_pkg::BYTE_W-1:0]      in_byte_reg;
    logic                              in_eot_reg;
    logic                              advance, can_load;
    kltok_pkg::res_load_t              load;

    assign advance       = in_valid_reg && can_load;
    assign s_ready       = !in_valid_reg || advance;
    assign in_valid_next = s_ready ? s_valid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
            in_eot_reg  <= s_end_of_text;
        end
    end

    kltok_scanner #(
        .POSITION_BITS (POSITION_BITS),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_scanner (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .text_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .load        (load)
    );

    kltok_result_buf u_result_buf (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load_en        (advance),
        .load           (load),
        .can_load       (can_load),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_token_kind   (m_token_kind),
        .m_token_start  (m_token_start),
        .m_token_length (m_token_length),
        .m_last_of_run  (m_last_of_run)
    );

`ifndef SYNTHESIS
    a_stalled_byte_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("A stalled source byte was lost or changed.");

    a_second_token_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> m_valid)
        else $error("A token that is not the last of its run had no successor.");

    a_token_length_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_token_length != '0))
        else $error("A token was presented with zero length.");

    a_no_load_while_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && !m_last_of_run) |-> !advance)
        else $error("The scan stage advanced while two tokens were still waiting.");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/keyword_lexer_tokenizer_core_tb.sv -----
// Self-checking testbench for keyword_lexer_tokenizer_core: streams source bytes and checks
// every token against a behavioral lexer kept in the testbench, under idle and stall phases.
// Depends on kltok_pkg and the keyword_lexer_tokenizer_core RTL.
`timescale 1ns / 1ps

module keyword_lexer_tokenizer_core_tb;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int PHASE_BYTES = 500;
    localparam int LONG_IDENT_BYTES = 20;
    localparam int SETTLE_CYCLES = 10;
    localparam int WORD_W = kltok_pkg::KW_BYTES * kltok_pkg::BYTE_W;
    localparam int LEN_W = kltok_pkg::TOKEN_LENGTH_W;
    localparam int BW = kltok_pkg::BYTE_W;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    typedef struct {
        logic [BW-1:0] ch;
        logic          eot;
    } src_item_t;

    logic                                    aclk = 1'b0;
    logic                                    aresetn = 1'b0;
    logic                                    s_valid = 1'b0;
    logic                                    s_ready;
    logic [BW-1:0]                           s_text_byte = '0;
    logic                                    s_end_of_text = 1'b0;
    logic                                    m_valid;
    logic                                    m_ready = 1'b0;
    logic [kltok_pkg::KIND_W-1:0]            m_token_kind;
    logic [kltok_pkg::TOKEN_START_W-1:0]     m_token_start;
    logic [LEN_W-1:0]                        m_token_length;
    logic                                    m_last_of_run;

    src_item_t          source_bytes[$];
    kltok_pkg::token_t  expected_tokens[$];
    int                 idle_pct = 0;
    int                 stall_pct = 0;
    int                 fail_count = 0;
    int                 cycle_count = 0;

    kltok_pkg::mode_t                     scan_mode = kltok_pkg::MODE_IDLE;
    logic [WORD_W-1:0]                    ident_word = '0;
    logic [kltok_pkg::TOKEN_START_W-1:0]  tok_start = '0;
    logic [LEN_W-1:0]                     tok_len = '0;
    logic [kltok_pkg::TOKEN_START_W-1:0]  text_pos = '0;
    int                                   run_count;

    string word_pool [18] = '{"fn", "pub", "struct", "enum", "impl", "if", "else", "for",
                              "char", "i32", "ret", "return", "while", "retu", "structs",
                              "Fn", "_", "i3"};
    string ident_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
    string punct_chars = "+*;:(){}";

    keyword_lexer_tokenizer_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_token_start (m_token_start),
        .m_token_length(m_token_length),
        .m_last_of_run (m_last_of_run)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic is_letter(input logic [BW-1:0] c);
        return (c >= kltok_pkg::CH_LOWER_A && c <= kltok_pkg::CH_LOWER_Z) ||
               (c >= kltok_pkg::CH_UPPER_A && c <= kltok_pkg::CH_UPPER_Z);
    endfunction

    function automatic logic is_digit(input logic [BW-1:0] c);
        return c >= kltok_pkg::CH_DIGIT_0 && c <= kltok_pkg::CH_DIGIT_9;
    endfunction

    function automatic logic is_blank(input logic [BW-1:0] c);
        return c == kltok_pkg::CH_SPACE || (c >= kltok_pkg::CH_TAB && c <= kltok_pkg::CH_CR);
    endfunction

    function automatic logic [kltok_pkg::KIND_W-1:0] word_kind();
        if (tok_len > kltok_pkg::KW_BYTES) return kltok_pkg::KIND_IDENT;
        case (ident_word)
            "fn":     return kltok_pkg::KIND_FN;
            "pub":    return kltok_pkg::KIND_PUB;
            "struct": return kltok_pkg::KIND_STRUCT;
            "enum":   return kltok_pkg::KIND_ENUM;
            "impl":   return kltok_pkg::KIND_IMPL;
            "if":     return kltok_pkg::KIND_IF;
            "else":   return kltok_pkg::KIND_ELSE;
            "for":    return kltok_pkg::KIND_FOR;
            "char":   return kltok_pkg::KIND_CHAR;
            "i32":    return kltok_pkg::KIND_I32;
            "ret":    return kltok_pkg::KIND_RET;
            "return": return kltok_pkg::KIND_RET;
            default:  return kltok_pkg::KIND_IDENT;
        endcase
    endfunction

    task automatic note_token(input logic [kltok_pkg::KIND_W-1:0] kind,
                              input logic [kltok_pkg::TOKEN_START_W-1:0] start,
                              input logic [LEN_W-1:0] len);
        kltok_pkg::token_t tok;
        tok.kind = kind;
        tok.start = start;
        tok.length = len;
        tok.last = 1'b0;
        expected_tokens.push_back(tok);
        run_count++;
    endtask

    task automatic open_token(input logic [BW-1:0] c);
        logic [kltok_pkg::KIND_W-1:0] kind;
        kind = kltok_pkg::KIND_UNKNOWN;
        tok_start = text_pos;
        tok_len = LEN_W'(1);
        if (is_blank(c)) return;
        if (is_letter(c) || c == kltok_pkg::CH_UNDERSCORE) begin
            ident_word = WORD_W'(c);
            scan_mode = kltok_pkg::MODE_IDENT;
            return;
        end
        if (is_digit(c)) begin
            scan_mode = kltok_pkg::MODE_NUMBER;
            return;
        end
        if (c == kltok_pkg::CH_MINUS) begin
            scan_mode = kltok_pkg::MODE_MINUS;
            return;
        end
        if (c == kltok_pkg::CH_SLASH) begin
            scan_mode = kltok_pkg::MODE_SLASH;
            return;
        end
        case (c)
            kltok_pkg::CH_PLUS:  kind = kltok_pkg::KIND_PLUS;
            kltok_pkg::CH_STAR:  kind = kltok_pkg::KIND_STAR;
            kltok_pkg::CH_SEMI:  kind = kltok_pkg::KIND_SEMI;
            kltok_pkg::CH_COLON: kind = kltok_pkg::KIND_COLON;
            kltok_pkg::CH_LPAR:  kind = kltok_pkg::KIND_LPAR;
            kltok_pkg::CH_RPAR:  kind = kltok_pkg::KIND_RPAR;
            kltok_pkg::CH_LCURL: kind = kltok_pkg::KIND_LCURL;
            kltok_pkg::CH_RCURL: kind = kltok_pkg::KIND_RCURL;
            default:             kind = kltok_pkg::KIND_UNKNOWN;
        endcase
        note_token(kind, text_pos, LEN_W'(1));
    endtask

    task automatic scan_byte(input logic [BW-1:0] c, input logic eot);
        kltok_pkg::token_t tok;
        run_count = 0;
        case (scan_mode)
            kltok_pkg::MODE_IDENT: begin
                if (is_letter(c) || is_digit(c) || c == kltok_pkg::CH_UNDERSCORE) begin
                    if (tok_len < kltok_pkg::KW_BYTES) ident_word = {ident_word[WORD_W-BW-1:0], c};
                    if (tok_len != LEN_MAX) tok_len++;
                end else begin
                    note_token(word_kind(), tok_start, tok_len);
                    scan_mode = kltok_pkg::MODE_IDLE;
                    open_token(c);
                end
            end
            kltok_pkg::MODE_NUMBER: begin
                if (is_digit(c)) begin
                    if (tok_len != LEN_MAX) tok_len++;
                end else begin
                    note_token(kltok_pkg::KIND_INT, tok_start, tok_len);
                    scan_mode = kltok_pkg::MODE_IDLE;
                    open_token(c);
                end
            end
            kltok_pkg::MODE_MINUS: begin
                scan_mode = kltok_pkg::MODE_IDLE;
                if (c == kltok_pkg::CH_GT) begin
                    note_token(kltok_pkg::KIND_ARROW, tok_start, LEN_W'(2));
                end else begin
                    note_token(kltok_pkg::KIND_MINUS, tok_start, LEN_W'(1));
                    open_token(c);
                end
            end
            kltok_pkg::MODE_SLASH: begin
                if (c == kltok_pkg::CH_STAR) begin
                    scan_mode = kltok_pkg::MODE_BLOCK;
                end else if (c == kltok_pkg::CH_SLASH) begin
                    scan_mode = kltok_pkg::MODE_LINE;
                end else begin
                    scan_mode = kltok_pkg::MODE_IDLE;
                    note_token(kltok_pkg::KIND_SLASH, tok_start, LEN_W'(1));
                    open_token(c);
                end
            end
            kltok_pkg::MODE_LINE: begin
                if (c == kltok_pkg::CH_LF || c == kltok_pkg::CH_CR) begin
                    scan_mode = kltok_pkg::MODE_IDLE;
                end
            end
            kltok_pkg::MODE_BLOCK: begin
                if (c == kltok_pkg::CH_STAR) scan_mode = kltok_pkg::MODE_BLOCK_STAR;
            end
            kltok_pkg::MODE_BLOCK_STAR: begin
                if (c == kltok_pkg::CH_SLASH) scan_mode = kltok_pkg::MODE_IDLE;
                else if (c != kltok_pkg::CH_STAR) scan_mode = kltok_pkg::MODE_BLOCK;
            end
            default: begin
                scan_mode = kltok_pkg::MODE_IDLE;
                open_token(c);
            end
        endcase
        if (eot) begin
            case (scan_mode)
                kltok_pkg::MODE_IDENT:  note_token(word_kind(), tok_start, tok_len);
                kltok_pkg::MODE_NUMBER: note_token(kltok_pkg::KIND_INT, tok_start, tok_len);
                kltok_pkg::MODE_MINUS:  note_token(kltok_pkg::KIND_MINUS, tok_start, LEN_W'(1));
                kltok_pkg::MODE_SLASH:  note_token(kltok_pkg::KIND_SLASH, tok_start, LEN_W'(1));
                default: ;
            endcase
            scan_mode = kltok_pkg::MODE_IDLE;
        end
        text_pos++;
        if (run_count > 0) begin
            tok = expected_tokens.pop_back();
            tok.last = 1'b1;
            expected_tokens.push_back(tok);
        end
    endtask

    task automatic add_byte(input logic [BW-1:0] c, input logic eot);
        src_item_t item;
        item.ch = c;
        item.eot = eot;
        source_bytes.push_back(item);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
    endtask

    task automatic add_blank();
        if ($urandom_range(1)) add_byte(kltok_pkg::CH_SPACE, 1'b0);
        else add_byte(BW'($urandom_range(kltok_pkg::CH_TAB, kltok_pkg::CH_CR)), 1'b0);
    endtask

    task automatic add_random_piece();
        int n;
        src_item_t item;
        case ($urandom_range(13))
            0, 1, 2: add_text(word_pool[$urandom_range(17)]);
            3: begin
                n = $urandom_range(1, 9);
                add_byte(ident_chars[$urandom_range(52)], 1'b0);
                repeat (n - 1) add_byte(ident_chars[$urandom_range(62)], 1'b0);
            end
            4: begin
                n = $urandom_range(1, 8);
                repeat (n) add_byte(BW'(kltok_pkg::CH_DIGIT_0 + $urandom_range(9)), 1'b0);
            end
            5: add_byte(punct_chars[$urandom_range(7)], 1'b0);
            6: begin
                if ($urandom_range(1)) add_text("->");
                else add_byte(kltok_pkg::CH_MINUS, 1'b0);
            end
            7: add_byte(kltok_pkg::CH_SLASH, 1'b0);
            8: begin
                add_text("//");
                n = $urandom_range(0, 12);
                repeat (n) add_byte(BW'($urandom_range(255)), $urandom_range(24) == 0);
                add_byte($urandom_range(1) ? kltok_pkg::CH_LF : kltok_pkg::CH_CR, 1'b0);
            end
            9: begin
                add_text("/*");
                n = $urandom_range(0, 12);
                repeat (n) begin
                    if ($urandom_range(2) == 0) add_byte(kltok_pkg::CH_STAR, 1'b0);
                    else add_byte(BW'($urandom_range(255)), $urandom_range(24) == 0);
                end
                if ($urandom_range(1)) add_text("*/");
                else add_text("**/");
            end
            10: begin
                n = $urandom_range(1, 3);
                repeat (n) add_blank();
            end
            11: add_byte(BW'($urandom_range(255)), 1'b0);
            12: add_byte(BW'($urandom_range(33, 126)), 1'b0);
            default: begin
                case ($urandom_range(2))
                    0: add_text("*/");
                    1: add_text("/*x");
                    default: add_byte(kltok_pkg::CH_MINUS, 1'b1);
                endcase
            end
        endcase
        if ($urandom_range(2) == 0) add_blank();
        if ($urandom_range(29) == 0) begin
            item = source_bytes.pop_back();
            item.eot = 1'b1;
            source_bytes.push_back(item);
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (source_bytes.size() != 0 || s_valid || expected_tokens.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        src_item_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                scan_byte(s_text_byte, s_end_of_text);
            end
            if (!s_valid || s_ready) begin
                if (source_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    item = source_bytes.pop_front();
                    s_valid <= 1'b1;
                    s_text_byte <= item.ch;
                    s_end_of_text <= item.eot;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        kltok_pkg::token_t tok;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token transaction: kind %0d start %0d length %0d",
                           m_token_kind, m_token_start, m_token_length);
                    fail_count++;
                end else begin
                    tok = expected_tokens.pop_front();
                    if (m_token_kind !== tok.kind) begin
                        $error("token_kind expected %0d actual %0d", tok.kind, m_token_kind);
                        fail_count++;
                    end
                    if (m_token_start !== tok.start) begin
                        $error("token_start expected %0d actual %0d", tok.start, m_token_start);
                        fail_count++;
                    end
                    if (m_token_length !== tok.length) begin
                        $error("token_length expected %0d actual %0d",
                               tok.length, m_token_length);
                        fail_count++;
                    end
                    if (m_last_of_run !== tok.last) begin
                        $error("last_of_run expected %0d actual %0d", tok.last, m_last_of_run);
                        fail_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int target;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            if (phase == 0) begin
                add_text("if)_a1->-7/**x**/+//");
                add_byte(kltok_pkg::CH_LF, 1'b0);
                add_byte(8'hFF, 1'b0);
                add_byte(8'h00, 1'b1);
                add_text("/*");
                add_byte("q", 1'b1);
                add_byte(kltok_pkg::CH_MINUS, 1'b1);
                repeat (LONG_IDENT_BYTES) add_byte("a", 1'b0);
                add_byte(kltok_pkg::CH_SPACE, 1'b0);
            end
            target = source_bytes.size() + PHASE_BYTES;
            while (source_bytes.size() < target) add_random_piece();
            wait_drained();
        end
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
